/* hdl/tcu_pkg.sv */
// shared types, constants and helpers for the triangle half-space clip unit
`timescale 1ns / 1ps
`default_nettype none
package tcu_pkg;

    // coordinate sign extension width
    localparam int COORD_BITS = 32;
    localparam int COORD_W    = (COORD_BITS > 32) ? 32 : COORD_BITS;

    // field and datapath widths
    localparam int CRD_W   = 32;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 66;
    localparam int Q_SHIFT = 30;
    localparam int DIST_W  = 36;
    localparam int DEN_W   = 36;
    localparam int REM_W   = 37;
    localparam int T_W     = 32;
    localparam int HALF_W  = T_W / 2;
    localparam int MAG_W   = 33;
    localparam int PP_W    = MAG_W + HALF_W;
    localparam int MH_W    = PP_W + 1;
    localparam int TOL_W   = 31;

    // divider split: bits of quotient per pipeline stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = T_W / DIV_STEP;

    // pipeline stage numbering
    localparam int ST_PROD = 1;
    localparam int ST_DIST = 2;
    localparam int ST_DEN  = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_MUL  = ST_DIV0 + DIV_STAGES;
    localparam int ST_PT   = ST_MUL + 1;
    localparam int NSTAGE  = ST_PT;

    // result list
    localparam int MAX_ITEMS = 6;
    localparam int IDX_W     = $clog2(MAX_ITEMS);

    // stream widths
    localparam int S_DATA_W = 9 * CRD_W;
    localparam int M_DATA_W = 3 * CRD_W;
    localparam int M_USER_W = 8;

    // register file
    localparam int PADDR_W = 5;
    localparam int APB_W   = 32;
    typedef enum logic [2:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_PLANE_OFFSET,
        REG_TOLERANCE
    } reg_idx_t;

    localparam logic [CRD_W-1:0] RST_NORMAL_X = 32'd0;
    localparam logic [CRD_W-1:0] RST_NORMAL_Y = 32'd0;
    localparam logic [CRD_W-1:0] RST_NORMAL_Z = 32'd1073741824;
    localparam logic [CRD_W-1:0] RST_OFFSET   = 32'd0;
    localparam logic [TOL_W-1:0] RST_TOL      = 31'd16;

    // vertex class against the plane
    typedef enum logic [1:0] {
        CLS_ON,
        CLS_ABOVE,
        CLS_BELOW
    } cls_t;

    // result kind
    typedef enum logic [1:0] {
        KIND_POLY  = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2,
        KIND_EMPTY = 2'd3
    } kind_t;

    typedef logic [2:0][CRD_W-1:0] point_t;
    typedef point_t [2:0] tri_t;

    typedef struct packed {
        kind_t  kind;
        point_t pt;
    } item_t;

    // sign extend a coordinate from its configured width
    function automatic logic [CRD_W-1:0] sext_coord(input logic [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] s;
        s = $signed(v << (CRD_W - COORD_W));
        return CRD_W'(s >>> (CRD_W - COORD_W));
    endfunction

    // next vertex index, modulo three
    function automatic logic [1:0] inc3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

endpackage
`default_nettype wire

/* hdl/triangle_halfspace_clip_unit.sv */
// top level of the triangle half-space clip unit
//
// Usage: one triangle (nine signed Q16.16 coordinates) enters per request on
// the s_ stream; the clipped lower polygon, then the cut segment, leave as
// separate requests on the m_ stream, tlast marking a triangle's final one.
// A triangle with nothing below the plane gives one empty request, hit low.
// Plane normal, offset and tolerance are set through the APB port; the user
// must write it only while the unit is idle, which the unit does not enforce;
// reads return the register contents. The result channel sends one request
// per cycle while m_tready is high, and a triangle has 1 to 6 result
// requests; the 13-stage pipeline of distance, divider and scale lanes takes
// a new triangle each cycle while there is room.
// A distance lane per vertex and a crossing lane per edge run side by side.
// Reset empties the pipeline and loads normal (0, 0, 1.0), offset 0 and
// tolerance 16. When the receiver stalls, the result list is held and the
// pipeline fills up behind it before s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module triangle_halfspace_clip_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tcu_pkg::S_DATA_W-1:0]       s_tdata,   // v0_x,v0_y,v0_z,v1_x..v2_z
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tcu_pkg::M_DATA_W-1:0]            m_tdata,   // point_x, point_y, point_z
    output logic [tcu_pkg::M_USER_W-1:0]            m_tuser,   // kind[1:0], hit, zero pad
    output logic                                    m_tlast,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tcu_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [tcu_pkg::APB_W-1:0]          pwdata,
    output logic [tcu_pkg::APB_W-1:0]               prdata,
    output logic                                    pready
);

    localparam int N = tcu_pkg::NSTAGE;

    logic [tcu_pkg::CRD_W-1:0] normal_x_reg, normal_y_reg, normal_z_reg, offset_reg;
    logic [tcu_pkg::TOL_W-1:0] tol_reg;
    tcu_pkg::reg_idx_t         reg_idx;
    logic                      wr_en;

    logic [N:1]                valid_reg, valid_next, move, load;
    tcu_pkg::tri_t             vin;
    tcu_pkg::tri_t             vtx_reg [1:N];
    tcu_pkg::point_t           normal;
    logic signed [tcu_pkg::DIST_W-1:0] dval [3];
    tcu_pkg::cls_t             cls_d [3];
    tcu_pkg::cls_t             cls_pipe [tcu_pkg::ST_DEN:N][3];
    tcu_pkg::point_t           xpt [3];
    logic                      take;

    // register file access
    assign pready  = 1'b1;
    assign reg_idx = tcu_pkg::reg_idx_t'(paddr[tcu_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= tcu_pkg::RST_NORMAL_X;
            normal_y_reg <= tcu_pkg::RST_NORMAL_Y;
            normal_z_reg <= tcu_pkg::RST_NORMAL_Z;
            offset_reg   <= tcu_pkg::RST_OFFSET;
            tol_reg      <= tcu_pkg::RST_TOL;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tcu_pkg::REG_NORMAL_X:     normal_x_reg <= pwdata;
                tcu_pkg::REG_NORMAL_Y:     normal_y_reg <= pwdata;
                tcu_pkg::REG_NORMAL_Z:     normal_z_reg <= pwdata;
                tcu_pkg::REG_PLANE_OFFSET: offset_reg   <= pwdata;
                tcu_pkg::REG_TOLERANCE:    tol_reg      <= pwdata[tcu_pkg::TOL_W-1:0];
                default:                   ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            tcu_pkg::REG_NORMAL_X:     prdata = normal_x_reg;
            tcu_pkg::REG_NORMAL_Y:     prdata = normal_y_reg;
            tcu_pkg::REG_NORMAL_Z:     prdata = normal_z_reg;
            tcu_pkg::REG_PLANE_OFFSET: prdata = offset_reg;
            tcu_pkg::REG_TOLERANCE:    prdata = tcu_pkg::APB_W'(tol_reg);
            default:                   prdata = '0;
        endcase
    end

    assign normal = {normal_z_reg, normal_y_reg, normal_x_reg};

    // unpack and sign extend the vertices
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                vin[i][c] = tcu_pkg::sext_coord(s_tdata[(i*3+c)*tcu_pkg::CRD_W +: tcu_pkg::CRD_W]);
            end
        end
    end

    // pipeline flow: a stage moves on when the next one is free or moving
    always_comb
    begin
        move[N] = take;
        for (int k = N - 1; k >= 1; k--)
        begin
            move[k] = valid_reg[k] && (!valid_reg[k+1] || move[k+1]);
        end
        s_tready = !valid_reg[1] || move[1];
        load[1]  = s_tvalid && s_tready;
        for (int k = 2; k <= N; k++)
        begin
            load[k] = move[k-1];
        end
        for (int k = 1; k <= N; k++)
        begin
            valid_next[k] = load[k] || (valid_reg[k] && !move[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // vertex and class carry along the pipeline
    for (genvar k = 1; k <= N; k++)
    begin : g_vtx
        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                if (k == 1)
                    vtx_reg[k] <= vin;
                else
                    vtx_reg[k] <= vtx_reg[k-1];
            end
        end
    end

    for (genvar k = tcu_pkg::ST_DEN; k <= N; k++)
    begin : g_cls
        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                if (k == tcu_pkg::ST_DEN)
                    cls_pipe[k] <= cls_d;
                else
                    cls_pipe[k] <= cls_pipe[k-1];
            end
        end
    end

    // distance lanes, one per vertex
    for (genvar i = 0; i < 3; i++)
    begin : g_dist
        tcu_dist_lane u_dist (
            .clk     (clk),
            .en_prod (load[tcu_pkg::ST_PROD]),
            .en_dist (load[tcu_pkg::ST_DIST]),
            .normal  (normal),
            .offset  ($signed(offset_reg)),
            .tol     (tol_reg),
            .v       (vin[i]),
            .d       (dval[i]),
            .cls     (cls_d[i])
        );
    end

    // crossing lanes, one per edge i -> i+1
    for (genvar e = 0; e < 3; e++)
    begin : g_cross
        localparam int EN = (e + 1) % 3;
        tcu_cross_lane u_cross (
            .clk   (clk),
            .en    (load[tcu_pkg::ST_PT:tcu_pkg::ST_DEN]),
            .dp    (dval[e]),
            .dq    (dval[EN]),
            .p_den (vtx_reg[tcu_pkg::ST_DIST][e]),
            .q_den (vtx_reg[tcu_pkg::ST_DIST][EN]),
            .p_pt  (vtx_reg[tcu_pkg::ST_MUL][e]),
            .x     (xpt[e])
        );
    end

    // result merging and output
    tcu_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_reg[N]),
        .take     (take),
        .cls      (cls_pipe[N]),
        .v        (vtx_reg[N]),
        .xp       (xpt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    // an empty result is the only request of its triangle and has no hit
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == tcu_pkg::KIND_EMPTY) |-> m_tlast && !m_tuser[2])
        else $error("empty result not final or flagged as hit");

    // a cut end always closes the triangle's list
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == tcu_pkg::KIND_END) |-> m_tlast)
        else $error("cut end is not the final request");

    // a finished triangle waiting on the merger is never dropped
    a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] && !take |=> valid_reg[N])
        else $error("last pipeline stage lost a triangle");
`endif

endmodule
`default_nettype wire

/* hdl/tcu_dist_lane.sv */
// signed plane distance and classification of one vertex
`timescale 1ns / 1ps
`default_nettype none
module tcu_dist_lane (
    input  wire logic                              clk,
    input  wire logic                              en_prod,
    input  wire logic                              en_dist,
    input  wire tcu_pkg::point_t                   normal,
    input  wire logic signed [tcu_pkg::CRD_W-1:0]  offset,
    input  wire logic [tcu_pkg::TOL_W-1:0]         tol,
    input  wire tcu_pkg::point_t                   v,
    output logic signed [tcu_pkg::DIST_W-1:0]      d,
    output tcu_pkg::cls_t                          cls
);

    logic signed [tcu_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [tcu_pkg::PROD_W-1:0] prod_next [3];
    logic signed [tcu_pkg::SUM_W-1:0]  sum;
    logic signed [tcu_pkg::DIST_W-1:0] dist_reg;
    logic signed [tcu_pkg::DIST_W-1:0] dist_next;
    logic signed [tcu_pkg::DIST_W-1:0] tol_s;
    tcu_pkg::cls_t                     cls_reg;
    tcu_pkg::cls_t                     cls_next;

    // one product per axis
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = $signed(normal[c]) * $signed(v[c]);
        end
    end

    // exact floor of the sum, then offset and band test
    always_comb
    begin
        sum = tcu_pkg::SUM_W'(prod_reg[0]) + tcu_pkg::SUM_W'(prod_reg[1])
            + tcu_pkg::SUM_W'(prod_reg[2]);
        dist_next = $signed(sum[tcu_pkg::Q_SHIFT +: tcu_pkg::DIST_W])
                  + tcu_pkg::DIST_W'(offset);
        tol_s = $signed(tcu_pkg::DIST_W'(tol));
        if (dist_next > tol_s)
            cls_next = tcu_pkg::CLS_ABOVE;
        else if (dist_next >= -tol_s)
            cls_next = tcu_pkg::CLS_ON;
        else
            cls_next = tcu_pkg::CLS_BELOW;
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (en_dist)
        begin
            dist_reg <= dist_next;
            cls_reg  <= cls_next;
        end
    end

    assign d   = dist_reg;
    assign cls = cls_reg;

endmodule
`default_nettype wire

/* hdl/tcu_cross_lane.sv */
// crossing point on one directed triangle edge, pipelined divide and scale
`timescale 1ns / 1ps
`default_nettype none
module tcu_cross_lane (
    input  wire logic                                   clk,
    input  wire logic [tcu_pkg::ST_PT:tcu_pkg::ST_DEN]  en,
    input  wire logic signed [tcu_pkg::DIST_W-1:0]      dp,
    input  wire logic signed [tcu_pkg::DIST_W-1:0]      dq,
    input  wire tcu_pkg::point_t                        p_den,
    input  wire tcu_pkg::point_t                        q_den,
    input  wire tcu_pkg::point_t                        p_pt,
    output tcu_pkg::point_t                             x
);

    localparam int NDS = tcu_pkg::DIV_STAGES;

    // denominator stage
    logic [tcu_pkg::DEN_W-1:0] n_reg, den_reg, n_next, den_next;
    logic [tcu_pkg::MAG_W-1:0] am0_reg [3];
    logic [tcu_pkg::MAG_W-1:0] am0_next [3];
    logic [2:0]                an0_reg, an0_next;

    // divider stages
    logic [tcu_pkg::REM_W-1:0] rem_reg  [NDS];
    logic [tcu_pkg::REM_W-1:0] rem_next [NDS];
    logic [tcu_pkg::DEN_W-1:0] dv_reg   [NDS];
    logic [tcu_pkg::T_W-1:0]   t_reg    [NDS];
    logic [tcu_pkg::T_W-1:0]   t_next   [NDS];
    logic [tcu_pkg::MAG_W-1:0] am_reg   [NDS][3];
    logic [2:0]                an_reg   [NDS];

    // scale stages
    logic [tcu_pkg::PP_W-1:0]  ph_reg [3];
    logic [tcu_pkg::PP_W-1:0]  pl_reg [3];
    logic [tcu_pkg::PP_W-1:0]  ph_next [3];
    logic [tcu_pkg::PP_W-1:0]  pl_next [3];
    logic [2:0]                anm_reg;
    logic [tcu_pkg::MH_W-1:0]  mh [3];
    logic [tcu_pkg::CRD_W-1:0] off [3];
    tcu_pkg::point_t           x_reg, x_next;

    // magnitudes of the distances and of the edge vector
    always_comb
    begin
        logic signed [tcu_pkg::MAG_W-1:0] diff;
        n_next   = dp[tcu_pkg::DIST_W-1] ? tcu_pkg::DEN_W'(-dp) : tcu_pkg::DEN_W'(dp);
        den_next = n_next
                 + (dq[tcu_pkg::DIST_W-1] ? tcu_pkg::DEN_W'(-dq) : tcu_pkg::DEN_W'(dq));
        for (int c = 0; c < 3; c++)
        begin
            diff = tcu_pkg::MAG_W'($signed(q_den[c])) - tcu_pkg::MAG_W'($signed(p_den[c]));
            an0_next[c] = diff[tcu_pkg::MAG_W-1];
            am0_next[c] = diff[tcu_pkg::MAG_W-1] ? tcu_pkg::MAG_W'(-diff)
                                                 : tcu_pkg::MAG_W'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[tcu_pkg::ST_DEN])
        begin
            n_reg   <= n_next;
            den_reg <= den_next;
            am0_reg <= am0_next;
            an0_reg <= an0_next;
        end
    end

    // restoring divide, a few quotient bits per stage
    for (genvar j = 0; j < NDS; j++)
    begin : g_div
        always_comb
        begin
            logic [tcu_pkg::REM_W-1:0] r;
            logic [tcu_pkg::T_W-1:0]   tt;
            logic [tcu_pkg::DEN_W-1:0] dd;
            if (j == 0)
            begin
                r  = tcu_pkg::REM_W'(n_reg);
                tt = '0;
                dd = den_reg;
            end
            else
            begin
                r  = rem_reg[j-1];
                tt = t_reg[j-1];
                dd = dv_reg[j-1];
            end
            for (int s = 0; s < tcu_pkg::DIV_STEP; s++)
            begin
                r = {r[tcu_pkg::REM_W-2:0], 1'b0};
                if (r >= tcu_pkg::REM_W'(dd))
                begin
                    r  = r - tcu_pkg::REM_W'(dd);
                    tt = {tt[tcu_pkg::T_W-2:0], 1'b1};
                end
                else
                begin
                    tt = {tt[tcu_pkg::T_W-2:0], 1'b0};
                end
            end
            rem_next[j] = r;
            t_next[j]   = tt;
        end

        always_ff @(posedge clk)
        begin
            if (en[tcu_pkg::ST_DIV0 + j])
            begin
                rem_reg[j] <= rem_next[j];
                t_reg[j]   <= t_next[j];
                if (j == 0)
                begin
                    dv_reg[j] <= den_reg;
                    am_reg[j] <= am0_reg;
                    an_reg[j] <= an0_reg;
                end
                else
                begin
                    dv_reg[j] <= dv_reg[j-1];
                    am_reg[j] <= am_reg[j-1];
                    an_reg[j] <= an_reg[j-1];
                end
            end
        end
    end

    // partial products of the edge vector and the fraction halves
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ph_next[c] = tcu_pkg::PP_W'(am_reg[NDS-1][c])
                       * tcu_pkg::PP_W'(t_reg[NDS-1][tcu_pkg::T_W-1:tcu_pkg::HALF_W]);
            pl_next[c] = tcu_pkg::PP_W'(am_reg[NDS-1][c])
                       * tcu_pkg::PP_W'(t_reg[NDS-1][tcu_pkg::HALF_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[tcu_pkg::ST_MUL])
        begin
            ph_reg  <= ph_next;
            pl_reg  <= pl_next;
            anm_reg <= an_reg[NDS-1];
        end
    end

    // round half away from zero and step from the start vertex
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mh[c]  = tcu_pkg::MH_W'(ph_reg[c]) + tcu_pkg::MH_W'(pl_reg[c] >> tcu_pkg::HALF_W)
                   + (tcu_pkg::MH_W'(1) << (tcu_pkg::HALF_W - 1));
            off[c] = mh[c][tcu_pkg::HALF_W +: tcu_pkg::CRD_W];
            x_next[c] = anm_reg[c] ? p_pt[c] - off[c] : p_pt[c] + off[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[tcu_pkg::ST_PT])
        begin
            x_reg <= x_next;
        end
    end

    assign x = x_reg;

endmodule
`default_nettype wire

/* hdl/tcu_merge.sv */
// combines lane results into the ordered result list and sends it out
`timescale 1ns / 1ps
`default_nettype none
module tcu_merge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   take,
    input  wire tcu_pkg::cls_t                     cls [3],
    input  wire tcu_pkg::tri_t                     v,
    input  wire tcu_pkg::point_t                   xp [3],
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tcu_pkg::M_DATA_W-1:0]           m_tdata,   // point_x, point_y, point_z
    output logic [tcu_pkg::M_USER_W-1:0]           m_tuser,   // kind[1:0], hit, zero pad
    output logic                                   m_tlast
);

    tcu_pkg::item_t           list_reg [tcu_pkg::MAX_ITEMS];
    tcu_pkg::item_t           list_next [tcu_pkg::MAX_ITEMS];
    logic [tcu_pkg::IDX_W-1:0] idx_reg, lastidx_reg, lastidx_next;
    logic                     hit_reg, hit_next, busy_reg;
    logic                     out_last;

    // build the result list from the vertex classes
    always_comb
    begin
        logic [1:0] nb, nu, non, k, k1, k2, o, l, u, a, b, e;
        tcu_pkg::cls_t want;
        nb = '0; nu = '0; non = '0;
        o = '0; l = '0; u = '0; k = '0;
        for (int i = 0; i < 3; i++)
        begin
            case (cls[i])
                tcu_pkg::CLS_ON:    begin non = non + 2'd1; o = 2'(i); end
                tcu_pkg::CLS_ABOVE: begin nu = nu + 2'd1; u = 2'(i); end
                default:            begin nb = nb + 2'd1; l = 2'(i); end
            endcase
        end
        want = (nu == 2'd1) ? tcu_pkg::CLS_ABOVE : tcu_pkg::CLS_BELOW;
        for (int i = 0; i < 3; i++)
        begin
            if (cls[i] == want)
                k = 2'(i);
        end
        k1 = tcu_pkg::inc3(k);
        k2 = tcu_pkg::inc3(k1);
        if (cls[0] == tcu_pkg::CLS_ON && cls[1] == tcu_pkg::CLS_ON)
        begin
            a = 2'd0; b = 2'd1;
        end
        else if (cls[1] == tcu_pkg::CLS_ON && cls[2] == tcu_pkg::CLS_ON)
        begin
            a = 2'd1; b = 2'd2;
        end
        else
        begin
            a = 2'd2; b = 2'd0;
        end
        e = (u == tcu_pkg::inc3(l)) ? l : u;

        for (int i = 0; i < tcu_pkg::MAX_ITEMS; i++)
        begin
            list_next[i] = '{kind: tcu_pkg::KIND_POLY, pt: '0};
        end
        hit_next     = 1'b1;
        lastidx_next = '0;

        if (nb == 2'd0)
        begin
            // nothing below the band
            list_next[0] = '{kind: tcu_pkg::KIND_EMPTY, pt: '0};
            hit_next     = 1'b0;
        end
        else if (nu == 2'd0)
        begin
            // whole triangle below, cut only along an on-plane edge
            list_next[0] = '{kind: tcu_pkg::KIND_POLY, pt: v[0]};
            list_next[1] = '{kind: tcu_pkg::KIND_POLY, pt: v[1]};
            list_next[2] = '{kind: tcu_pkg::KIND_POLY, pt: v[2]};
            lastidx_next = tcu_pkg::IDX_W'(2);
            if (non == 2'd2)
            begin
                list_next[3] = '{kind: tcu_pkg::KIND_START, pt: v[a]};
                list_next[4] = '{kind: tcu_pkg::KIND_END, pt: v[b]};
                lastidx_next = tcu_pkg::IDX_W'(4);
            end
        end
        else if (non == 2'd0)
        begin
            if (nu == 2'd1)
            begin
                // one above: quad
                list_next[0] = '{kind: tcu_pkg::KIND_POLY, pt: xp[k]};
                list_next[1] = '{kind: tcu_pkg::KIND_POLY, pt: v[k1]};
                list_next[2] = '{kind: tcu_pkg::KIND_POLY, pt: v[k2]};
                list_next[3] = '{kind: tcu_pkg::KIND_POLY, pt: xp[k2]};
                list_next[4] = '{kind: tcu_pkg::KIND_START, pt: xp[k]};
                list_next[5] = '{kind: tcu_pkg::KIND_END, pt: xp[k2]};
                lastidx_next = tcu_pkg::IDX_W'(5);
            end
            else
            begin
                // one below: small triangle
                list_next[0] = '{kind: tcu_pkg::KIND_POLY, pt: v[k]};
                list_next[1] = '{kind: tcu_pkg::KIND_POLY, pt: xp[k]};
                list_next[2] = '{kind: tcu_pkg::KIND_POLY, pt: xp[k2]};
                list_next[3] = '{kind: tcu_pkg::KIND_START, pt: xp[k]};
                list_next[4] = '{kind: tcu_pkg::KIND_END, pt: xp[k2]};
                lastidx_next = tcu_pkg::IDX_W'(4);
            end
        end
        else
        begin
            // one on, one above, one below
            list_next[0] = '{kind: tcu_pkg::KIND_POLY, pt: v[o]};
            list_next[1] = '{kind: tcu_pkg::KIND_POLY, pt: v[l]};
            list_next[2] = '{kind: tcu_pkg::KIND_POLY, pt: xp[e]};
            list_next[3] = '{kind: tcu_pkg::KIND_START, pt: v[o]};
            list_next[4] = '{kind: tcu_pkg::KIND_END, pt: xp[e]};
            lastidx_next = tcu_pkg::IDX_W'(4);
        end
    end

    // take a new triangle when empty or on the final request going out
    assign out_last = (idx_reg == lastidx_reg);
    assign take     = in_valid && (!busy_reg || (m_tready && out_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (out_last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + tcu_pkg::IDX_W'(1);
        end
    end

    // held result list
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            list_reg    <= list_next;
            lastidx_reg <= lastidx_next;
            hit_reg     <= hit_next;
        end
    end

    // output port drive
    assign m_tvalid = busy_reg;
    assign m_tdata  = list_reg[idx_reg].pt;
    assign m_tuser  = tcu_pkg::M_USER_W'({hit_reg, list_reg[idx_reg].kind});
    assign m_tlast  = out_last;

endmodule
`default_nettype wire
